/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on the rising clock edge, off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/sric_pkg.sv */
// types, codes and helpers of the source rate intrusion filter
// no dependencies
package sric_pkg;

   localparam int FLOW_DEPTH_DEF   = 64;
   localparam int RECENT_DEPTH_DEF = 16;
   localparam int TRUST_DEPTH_DEF  = 16;
   localparam int QUEUE_DEPTH      = 2;

   localparam logic [31:0] TRUST_ADDR0 = 32'h7F00_0001;
   localparam logic [31:0] TRUST_ADDR1 = 32'hC0A8_0101;

   localparam logic [3:0]  THRESHOLD_RST = 4'd5;
   localparam logic [15:0] WINDOW_RST    = 16'd10;
   localparam logic [15:0] LARGE_RST     = 16'd1500;
   localparam logic [15:0] PORT_A_RST    = 16'd23;
   localparam logic [15:0] PORT_B_RST    = 16'd3389;

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LARGE     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PORT_A    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PORT_B    = 3'd4;

   localparam logic [1:0] REQ_PACKET   = 2'd0;
   localparam logic [1:0] REQ_TRUST    = 2'd1;
   localparam logic [1:0] REQ_UNBLOCK  = 2'd2;
   localparam logic [1:0] REQ_RESERVED = 2'd3;

   typedef enum logic [3:0] {
      V_TRUSTED       = 4'd0,
      V_BLOCKED       = 4'd1,
      V_CLEAN         = 4'd2,
      V_RATE          = 4'd3,
      V_OVERSIZE      = 4'd4,
      V_PORT          = 4'd5,
      V_TABLE_FULL    = 4'd6,
      V_TRUST_ADDED   = 4'd7,
      V_TRUST_FULL    = 4'd8,
      V_UNBLOCKED     = 4'd9,
      V_NOT_BLOCKED   = 4'd10
   } verdict_type;

   typedef enum logic [1:0] {
      CMD_PACKET,
      CMD_UNBLOCK,
      CMD_DONE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      verdict_type  verdict;
      logic [31:0]  ip;
      logic [31:0]  stamp;
      logic [15:0]  bytes;
      logic [15:0]  port;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic [3:0]  threshold;
      logic [15:0] window;
      logic [15:0] size_limit;
      logic [15:0] port_a;
      logic [15:0] port_b;
   } cfg_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_SCAN,
      B_HIT,
      B_MISS,
      B_PUSH,
      B_EXP_RD,
      B_EXP_CK,
      B_DECIDE,
      B_RESP
   } back_state_type;

   function automatic logic [31:0] sat_inc32(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

endpackage

/* hw/rtl/sric_channels.sv */
// request and response channel interfaces
// no dependencies
interface sric_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] source_ip;
   logic [31:0] arrival_time;
   logic [15:0] packet_bytes;
   logic [15:0] dest_port;

   modport source (output valid, req_type, source_ip, arrival_time, packet_bytes, dest_port,
                   input ready);
   modport sink (input valid, req_type, source_ip, arrival_time, packet_bytes, dest_port,
                 output ready);
endinterface

interface sric_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  verdict;
   logic [4:0]  recent_count;
   logic [31:0] source_requests;
   logic [31:0] source_bytes;
   logic [31:0] blocked_total;
   logic [31:0] alerts_total;

   modport source (output valid, verdict, recent_count, source_requests, source_bytes,
                   blocked_total, alerts_total, input ready);
   modport sink (input valid, verdict, recent_count, source_requests, source_bytes,
                 blocked_total, alerts_total, output ready);
endinterface

/* hw/rtl/source_rate_intrusion_filter_core.sv */
// source rate intrusion filter, top level
// depends on sric_pkg, sric_channels, sric_front, sric_queue, sric_back, assert_macros.svh
//
// req_chan carries packet headers and trust or unblock requests, rsp_chan one
// result word per request, in order. csr_we/csr_index/csr_wdata write the five
// settings; write them only while no request is in flight.
// The front matches a request against the trusted list and pushes it into a two
// entry queue, so it keeps accepting while the back works or the receiver
// stalls, until that queue is full. The back scans the flow table memory one
// entry per cycle, then for a packet pushes the stamp and drops expired ones;
// trust and reserved requests go straight to the response register, which
// holds a result while rsp_chan.ready is low and the back waits on it.
// Reset empties the flow table (fill count to zero), reloads the trusted list
// with its two default entries, clears the totals and restores the settings.
`include "assert_macros.svh"

module source_rate_intrusion_filter_core import sric_pkg::*; #(
   parameter int FLOW_DEPTH   = FLOW_DEPTH_DEF,
   parameter int RECENT_DEPTH = RECENT_DEPTH_DEF,
   parameter int TRUST_DEPTH  = TRUST_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   sric_req_if.sink               req_chan,
   sric_rsp_if.source             rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]            csr_wdata
);
   cfg_type      cfg_ff, cfg_in;
   logic         q_push, q_pop;
   cmd_type      push_cmd, head_cmd;
   q_status_type q_status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_THRESHOLD: cfg_in.threshold  = csr_wdata[3:0];
            CSR_WINDOW:    cfg_in.window     = csr_wdata;
            CSR_LARGE:     cfg_in.size_limit = csr_wdata;
            CSR_PORT_A:    cfg_in.port_a     = csr_wdata;
            CSR_PORT_B:    cfg_in.port_b     = csr_wdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold  <= THRESHOLD_RST;
         cfg_ff.window     <= WINDOW_RST;
         cfg_ff.size_limit <= LARGE_RST;
         cfg_ff.port_a     <= PORT_A_RST;
         cfg_ff.port_b     <= PORT_B_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sric_front #(.TRUST_DEPTH(TRUST_DEPTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_status.full),
      .q_push   (q_push),
      .q_cmd    (push_cmd)
   );

   sric_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   sric_back #(.FLOW_DEPTH(FLOW_DEPTH), .RECENT_DEPTH(RECENT_DEPTH)) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .head_cmd (head_cmd),
      .q_status (q_status),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

   // no write into a full queue, no read from an empty one
   `ASSERT_CLK(a_push_not_full, clock, reset, q_push |-> !q_status.full, "push into full queue")
   `ASSERT_CLK(a_pop_not_empty, clock, reset, q_pop |-> !q_status.empty, "pop from empty queue")
   // a push that is not drained leaves the queue non-empty
   `ASSERT_CLK(a_push_lands, clock, reset, (q_push && !q_pop) |=> !q_status.empty, "push lost")
endmodule

/* hw/rtl/sric_ram.sv */
// generic single write, single read ram with registered read
// no dependencies
module sric_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* hw/rtl/sric_queue.sv */
// short command queue between front and back
// depends on sric_pkg
module sric_queue import sric_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cmd_type      push_cmd,
   input  logic         pop,
   output cmd_type      head_cmd,
   output q_status_type status
);
   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cmd_type         slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   count_ff, count_in;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   always_comb begin
      wr_in    = push ? bump(wr_ff) : wr_ff;
      rd_in    = pop ? bump(rd_ff) : rd_ff;
      count_in = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

   assign head_cmd     = slot_ff[rd_ff];
   assign status.full  = (count_ff == CW'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
endmodule

/* hw/rtl/sric_front.sv */
// front end: accepts requests, keeps the trusted list, classifies each word
// depends on sric_pkg and sric_channels
module sric_front import sric_pkg::*; #(
   parameter int TRUST_DEPTH = TRUST_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   sric_req_if.sink   req_chan,
   input  logic       q_full,
   output logic       q_push,
   output cmd_type    q_cmd
);
   localparam int TW = $clog2(TRUST_DEPTH);

   logic [31:0]   addr_ff  [TRUST_DEPTH];
   logic          valid_ff [TRUST_DEPTH];
   logic          hit;
   logic          free_found;
   logic [TW-1:0] free_idx;
   logic          accept;
   logic          tr_we;

   always_comb begin
      hit        = 1'b0;
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = 0; i < TRUST_DEPTH; i++) begin
         if (valid_ff[i] && addr_ff[i] == req_chan.source_ip) begin
            hit = 1'b1;
         end
         if (!free_found && !valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = TW'(i);
         end
      end
   end

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && !q_full;
   assign q_push         = accept;
   assign tr_we          = accept && req_chan.req_type == REQ_TRUST && !hit && free_found;

   always_comb begin
      q_cmd.ip    = req_chan.source_ip;
      q_cmd.stamp = req_chan.arrival_time;
      q_cmd.bytes = req_chan.packet_bytes;
      q_cmd.port  = req_chan.dest_port;
      unique case (req_chan.req_type)
         REQ_PACKET: begin
            q_cmd.kind    = hit ? CMD_DONE : CMD_PACKET;
            q_cmd.verdict = V_TRUSTED;
         end
         REQ_TRUST: begin
            q_cmd.kind    = CMD_DONE;
            q_cmd.verdict = (hit || free_found) ? V_TRUST_ADDED : V_TRUST_FULL;
         end
         REQ_UNBLOCK: begin
            q_cmd.kind    = CMD_UNBLOCK;
            q_cmd.verdict = V_NOT_BLOCKED;
         end
         REQ_RESERVED: begin
            q_cmd.kind    = CMD_DONE;
            q_cmd.verdict = V_NOT_BLOCKED;
         end
         default: begin
            q_cmd.kind    = CMD_DONE;
            q_cmd.verdict = V_NOT_BLOCKED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TRUST_DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
            addr_ff[i]  <= '0;
         end
         valid_ff[0] <= 1'b1;
         valid_ff[1] <= 1'b1;
         addr_ff[0]  <= TRUST_ADDR0;
         addr_ff[1]  <= TRUST_ADDR1;
      end else if (tr_we) begin
         valid_ff[free_idx] <= 1'b1;
         addr_ff[free_idx]  <= req_chan.source_ip;
      end
   end
endmodule

/* hw/rtl/sric_back.sv */
// back end: flow table search, stamp ring update, alerts and response register
// depends on sric_pkg, sric_channels and sric_ram
module sric_back import sric_pkg::*; #(
   parameter int FLOW_DEPTH   = FLOW_DEPTH_DEF,
   parameter int RECENT_DEPTH = RECENT_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  cmd_type       head_cmd,
   input  q_status_type  q_status,
   output logic          q_pop,
   sric_rsp_if.source    rsp_chan
);
   localparam int FW   = $clog2(FLOW_DEPTH);
   localparam int CW   = $clog2(FLOW_DEPTH + 1);
   localparam int HW   = $clog2(RECENT_DEPTH);
   localparam int LW   = $clog2(RECENT_DEPTH + 1);
   localparam int SAW  = $clog2(FLOW_DEPTH * RECENT_DEPTH);
   localparam int RECW = 32 + 1 + 32 + 32 + HW + LW;

   back_state_type state_ff, state_in;
   cmd_type        cmd_ff, cmd_in;
   logic [CW-1:0]  scan_ff, scan_in, fill_ff, fill_in;
   logic           chk_v_ff, chk_v_in;
   logic [FW-1:0]  chk_idx_ff, chk_idx_in, f_ff, f_in;
   logic [31:0]    addr_ff, addr_in, reqs_ff, reqs_in, bytes_ff, bytes_in;
   logic           blk_ff, blk_in, use_rec_ff, use_rec_in;
   logic [HW-1:0]  head_ff, head_in;
   logic [LW-1:0]  len_ff, len_in;
   verdict_type    verdict_ff, verdict_in;
   logic [31:0]    blk_cnt_ff, blk_cnt_in, alert_cnt_ff, alert_cnt_in;

   logic           rsp_valid_ff, rsp_valid_in, load;
   logic [3:0]     o_verdict_ff;
   logic [4:0]     o_count_ff;
   logic [31:0]    o_reqs_ff, o_bytes_ff, o_blk_ff, o_alert_ff;

   logic            rec_we;
   logic [RECW-1:0] rec_wdata, rec_rdata;
   logic [31:0]     rd_addr, rd_reqs, rd_bytes;
   logic            rd_blk;
   logic [HW-1:0]   rd_head;
   logic [LW-1:0]   rd_len;

   logic            st_we;
   logic [SAW-1:0]  st_waddr, st_raddr, f_base;
   logic [31:0]     st_rdata, age;
   logic [LW:0]     slot_sum;
   logic [HW-1:0]   slot;
   logic            issue, match;

   function automatic logic [HW-1:0] bump(input logic [HW-1:0] h);
      return (h == HW'(RECENT_DEPTH - 1)) ? '0 : h + HW'(1);
   endfunction

   assign {rd_addr, rd_blk, rd_reqs, rd_bytes, rd_head, rd_len} = rec_rdata;

   sric_ram #(.WIDTH(RECW), .DEPTH(FLOW_DEPTH)) u_rec_ram (
      .clock (clock),
      .we    (rec_we),
      .waddr (f_ff),
      .wdata (rec_wdata),
      .raddr (scan_ff[FW-1:0]),
      .rdata (rec_rdata)
   );

   sric_ram #(.WIDTH(32), .DEPTH(FLOW_DEPTH * RECENT_DEPTH)) u_stamp_ram (
      .clock (clock),
      .we    (st_we),
      .waddr (st_waddr),
      .wdata (cmd_ff.stamp),
      .raddr (st_raddr),
      .rdata (st_rdata)
   );

   assign f_base   = SAW'(f_ff) * SAW'(RECENT_DEPTH);
   assign slot_sum = (LW+1)'(head_ff) + (LW+1)'(len_ff);
   assign slot     = (slot_sum >= (LW+1)'(RECENT_DEPTH)) ?
                     HW'(slot_sum - (LW+1)'(RECENT_DEPTH)) : HW'(slot_sum);
   assign st_raddr = f_base + SAW'(head_ff);
   assign age      = cmd_ff.stamp - st_rdata;
   assign issue    = (scan_ff != fill_ff);
   assign match    = chk_v_ff && (rd_addr == cmd_ff.ip);
   assign load     = (state_ff == B_RESP) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      scan_in      = scan_ff;
      fill_in      = fill_ff;
      chk_v_in     = 1'b0;
      chk_idx_in   = chk_idx_ff;
      f_in         = f_ff;
      addr_in      = addr_ff;
      blk_in       = blk_ff;
      reqs_in      = reqs_ff;
      bytes_in     = bytes_ff;
      head_in      = head_ff;
      len_in       = len_ff;
      use_rec_in   = use_rec_ff;
      verdict_in   = verdict_ff;
      blk_cnt_in   = blk_cnt_ff;
      alert_cnt_in = alert_cnt_ff;
      q_pop        = 1'b0;
      rec_we       = 1'b0;
      rec_wdata    = {addr_ff, blk_ff, reqs_ff, bytes_ff, head_ff, len_ff};
      st_we        = 1'b0;
      st_waddr     = f_base + SAW'(slot);
      unique case (state_ff)
         B_IDLE: begin
            if (!q_status.empty) begin
               q_pop      = 1'b1;
               cmd_in     = head_cmd;
               use_rec_in = 1'b0;
               verdict_in = head_cmd.verdict;
               scan_in    = '0;
               if (head_cmd.kind == CMD_DONE) begin
                  state_in = B_RESP;
               end else if (fill_ff == '0) begin
                  state_in = B_MISS;
               end else begin
                  state_in = B_SCAN;
               end
            end
         end
         B_SCAN: begin
            if (match) begin
               f_in     = chk_idx_ff;
               addr_in  = rd_addr;
               blk_in   = rd_blk;
               reqs_in  = rd_reqs;
               bytes_in = rd_bytes;
               head_in  = rd_head;
               len_in   = rd_len;
               state_in = B_HIT;
            end else if (issue) begin
               chk_v_in   = 1'b1;
               chk_idx_in = scan_ff[FW-1:0];
               scan_in    = scan_ff + CW'(1);
            end else if (chk_v_ff) begin
               state_in = B_MISS;
            end
         end
         B_HIT: begin
            if (cmd_ff.kind == CMD_UNBLOCK) begin
               if (blk_ff) begin
                  blk_in     = 1'b0;
                  rec_we     = 1'b1;
                  rec_wdata  = {addr_ff, 1'b0, reqs_ff, bytes_ff, head_ff, len_ff};
                  use_rec_in = 1'b1;
                  verdict_in = V_UNBLOCKED;
               end else begin
                  verdict_in = V_NOT_BLOCKED;
               end
               state_in = B_RESP;
            end else if (blk_ff) begin
               blk_cnt_in = sat_inc32(blk_cnt_ff);
               use_rec_in = 1'b1;
               verdict_in = V_BLOCKED;
               state_in   = B_RESP;
            end else begin
               state_in = B_PUSH;
            end
         end
         B_MISS: begin
            if (cmd_ff.kind == CMD_UNBLOCK) begin
               verdict_in = V_NOT_BLOCKED;
               state_in   = B_RESP;
            end else if (fill_ff == CW'(FLOW_DEPTH)) begin
               verdict_in = V_TABLE_FULL;
               state_in   = B_RESP;
            end else begin
               f_in     = fill_ff[FW-1:0];
               fill_in  = fill_ff + CW'(1);
               addr_in  = cmd_ff.ip;
               blk_in   = 1'b0;
               reqs_in  = '0;
               bytes_in = '0;
               head_in  = '0;
               len_in   = '0;
               state_in = B_PUSH;
            end
         end
         B_PUSH: begin
            reqs_in  = sat_inc32(reqs_ff);
            bytes_in = sat_add32(bytes_ff, {16'd0, cmd_ff.bytes});
            st_we    = 1'b1;
            if (len_ff == LW'(RECENT_DEPTH)) begin
               st_waddr = f_base + SAW'(head_ff);
               head_in  = bump(head_ff);
            end else begin
               len_in = len_ff + LW'(1);
            end
            state_in = B_EXP_RD;
         end
         B_EXP_RD: begin
            state_in = B_EXP_CK;
         end
         B_EXP_CK: begin
            if (len_ff != '0 && age > {16'd0, cfg.window}) begin
               head_in  = bump(head_ff);
               len_in   = len_ff - LW'(1);
               state_in = B_EXP_RD;
            end else begin
               state_in = B_DECIDE;
            end
         end
         B_DECIDE: begin
            priority if (32'(len_ff) > 32'(cfg.threshold)) begin
               verdict_in = V_RATE;
               blk_in     = 1'b1;
            end else if (cmd_ff.bytes > cfg.size_limit) begin
               verdict_in = V_OVERSIZE;
            end else if (cmd_ff.port == cfg.port_a || cmd_ff.port == cfg.port_b) begin
               verdict_in = V_PORT;
            end else begin
               verdict_in = V_CLEAN;
            end
            if (32'(len_ff) > 32'(cfg.threshold) || cmd_ff.bytes > cfg.size_limit ||
                cmd_ff.port == cfg.port_a || cmd_ff.port == cfg.port_b) begin
               alert_cnt_in = sat_inc32(alert_cnt_ff);
            end
            rec_we     = 1'b1;
            rec_wdata  = {addr_ff, (32'(len_ff) > 32'(cfg.threshold)) | blk_ff,
                          reqs_ff, bytes_ff, head_ff, len_ff};
            use_rec_in = 1'b1;
            state_in   = B_RESP;
         end
         B_RESP: begin
            if (load) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         fill_ff      <= '0;
         chk_v_ff     <= 1'b0;
         blk_cnt_ff   <= '0;
         alert_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         chk_v_ff     <= chk_v_in;
         blk_cnt_ff   <= blk_cnt_in;
         alert_cnt_ff <= alert_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff     <= cmd_in;
      scan_ff    <= scan_in;
      chk_idx_ff <= chk_idx_in;
      f_ff       <= f_in;
      addr_ff    <= addr_in;
      blk_ff     <= blk_in;
      reqs_ff    <= reqs_in;
      bytes_ff   <= bytes_in;
      head_ff    <= head_in;
      len_ff     <= len_in;
      use_rec_ff <= use_rec_in;
      verdict_ff <= verdict_in;
      if (load) begin
         o_verdict_ff <= verdict_ff;
         o_count_ff   <= use_rec_ff ? 5'(len_ff) : 5'd0;
         o_reqs_ff    <= use_rec_ff ? reqs_ff : 32'd0;
         o_bytes_ff   <= use_rec_ff ? bytes_ff : 32'd0;
         o_blk_ff     <= blk_cnt_ff;
         o_alert_ff   <= alert_cnt_ff;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.verdict         = o_verdict_ff;
   assign rsp_chan.recent_count    = o_count_ff;
   assign rsp_chan.source_requests = o_reqs_ff;
   assign rsp_chan.source_bytes    = o_bytes_ff;
   assign rsp_chan.blocked_total   = o_blk_ff;
   assign rsp_chan.alerts_total    = o_alert_ff;
endmodule
